/* rtl/mqsb_pkg.sv */
// ----------------------------------------------------------------------------
// mqsb_pkg
// shared constants, codes and types of the shared-buffer multi-queue
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int unsigned NumQueuesDef = 8;
  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned DataW        = 32;
  localparam int unsigned QidxW        = 3;
  localparam int unsigned StatusW      = 2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic head_we;
    logic tail_we;
  } ptr_we_t;

endpackage

/* rtl/multi_queue_shared_buffer_top.sv */
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// several fifo queues over one slot store, linked through a free list
// result beat: registered in the S_EXEC state that follows command accept
// a new command is not taken while busy in S_EXEC, which holds the write-back of
//   pointers and links after the link memory read at command accept
// reset: all queues empty, free list holds every slot in order; no clearing
//   pass, links of never-used slots come from a fill counter
// the result beat cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top import mqsb_pkg::*; #(
  parameter int unsigned NUM_QUEUES = NumQueuesDef,
  parameter int unsigned CAPACITY   = CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      kind_i,
  input  logic [QidxW-1:0]          queue_index_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      busy,
  output logic                      done_o,
  output logic [StatusW-1:0]        status_o,
  output logic signed [DataW-1:0]   data_out_o
);

  localparam int unsigned PtrW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned QiW   = (QW > QidxW) ? QW : QidxW;
  localparam logic [PtrW-1:0] NullPtr = PtrW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e          state_q;
  logic            kind_q;
  logic [QW-1:0]   qidx_q;
  logic [PtrW-1:0] slot_q;
  logic            ok_q;
  logic [PtrW-1:0] free_head_q, free_head_d;
  logic [PtrW-1:0] fill_q, fill_d;

  logic            accept;
  logic            exec;
  logic [QiW-1:0]  q_ext;
  logic [QW-1:0]   q_in_idx;
  logic            q_in_ok;
  logic [QW-1:0]   rd_idx;
  logic [PtrW-1:0] head_rd;
  logic [PtrW-1:0] tail_rd;
  logic            enq_ok_in;
  logic            deq_ok_in;
  logic            in_ok;
  logic [PtrW-1:0] slot_in;

  logic [PtrW-1:0]  link_rdata;
  logic [DataW-1:0] data_rdata;
  logic [PtrW-1:0]  link_val;
  logic             link_we;
  logic [PtrW-1:0]  link_wptr;
  logic [PtrW-1:0]  link_wdata;
  ptr_we_t          ptr_we;
  logic [PtrW-1:0]  head_wr;
  logic [PtrW-1:0]  tail_wr;

  logic [StatusW-1:0] status_d;
  logic [DataW-1:0]   data_d;

  assign accept = start && !busy;
  assign exec   = (state_q == S_EXEC);
  assign busy   = exec;

  assign q_ext    = QiW'(queue_index_i);
  assign q_in_idx = q_ext[QW-1:0];
  assign q_in_ok  = 32'(queue_index_i) < NUM_QUEUES;
  assign rd_idx   = exec ? qidx_q : q_in_idx;

  mqsb_ptr_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .CAPACITY   (CAPACITY)
  ) u_ptr_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .head_o   (head_rd),
    .tail_o   (tail_rd),
    .wr_idx_i (qidx_q),
    .we_i     (ptr_we),
    .head_i   (head_wr),
    .tail_i   (tail_wr)
  );

  assign enq_ok_in = q_in_ok && (free_head_q < NullPtr);
  assign deq_ok_in = q_in_ok && (head_rd < NullPtr);
  assign in_ok     = (kind_i == KIND_DEQ) ? deq_ok_in : enq_ok_in;
  assign slot_in   = (kind_i == KIND_DEQ) ? head_rd : free_head_q;

  mqsb_ram #(
    .WIDTH (DataW),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (kind_i == KIND_ENQ) && enq_ok_in),
    .waddr_i (free_head_q[AddrW-1:0]),
    .wdata_i (value_i),
    .re_i    (accept && in_ok),
    .raddr_i (slot_in[AddrW-1:0]),
    .rdata_o (data_rdata)
  );

  mqsb_ram #(
    .WIDTH (PtrW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wptr[AddrW-1:0]),
    .wdata_i (link_wdata),
    .re_i    (accept && in_ok),
    .raddr_i (slot_in[AddrW-1:0]),
    .rdata_o (link_rdata)
  );

  // slots at or above the fill mark were never touched and still link onward
  assign link_val = (slot_q >= fill_q) ? (slot_q + PtrW'(1)) : link_rdata;

  always_comb begin
    free_head_d = free_head_q;
    fill_d      = fill_q;
    ptr_we      = '0;
    head_wr     = slot_q;
    tail_wr     = slot_q;
    link_we     = 1'b0;
    link_wptr   = slot_q;
    link_wdata  = free_head_q;
    if (exec && ok_q) begin
      if (kind_q == KIND_ENQ) begin
        free_head_d    = link_val;
        fill_d         = (slot_q == fill_q) ? (fill_q + PtrW'(1)) : fill_q;
        ptr_we.tail_we = 1'b1;
        if (head_rd < NullPtr) begin
          link_we    = (tail_rd < NullPtr);
          link_wptr  = tail_rd;
          link_wdata = slot_q;
        end else begin
          ptr_we.head_we = 1'b1;
        end
      end else begin
        // the tail slot ends its chain
        ptr_we.head_we = 1'b1;
        head_wr        = (slot_q == tail_rd) ? NullPtr : link_val;
        free_head_d    = slot_q;
        link_we        = 1'b1;
      end
    end
  end

  always_comb begin
    if (ok_q) begin
      status_d = ST_OK;
    end else if (kind_q == KIND_ENQ) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_EMPTY;
    end
    data_d = (ok_q && (kind_q == KIND_DEQ)) ? data_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_ENQ;
      qidx_q      <= '0;
      slot_q      <= '0;
      ok_q        <= 1'b0;
      free_head_q <= '0;
      fill_q      <= '0;
      done_o      <= 1'b0;
      status_o    <= ST_OK;
      data_out_o  <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q  <= kind_i;
            qidx_q  <= q_in_idx;
            slot_q  <= slot_in;
            ok_q    <= in_ok;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          free_head_q <= free_head_d;
          fill_q      <= fill_d;
          done_o      <= 1'b1;
          status_o    <= status_d;
          data_out_o  <= data_d;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/mqsb_ram.sv */
// ----------------------------------------------------------------------------
// mqsb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/mqsb_ptr_table.sv */
// ----------------------------------------------------------------------------
// mqsb_ptr_table
// per-queue head and tail pointers, one read index and one write index
// ----------------------------------------------------------------------------
module mqsb_ptr_table import mqsb_pkg::*; #(
  parameter int unsigned NUM_QUEUES = NumQueuesDef,
  parameter int unsigned CAPACITY   = CapacityDef
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] rd_idx_i,
  output logic [$clog2(CAPACITY + 1)-1:0]                     head_o,
  output logic [$clog2(CAPACITY + 1)-1:0]                     tail_o,
  input  logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] wr_idx_i,
  input  ptr_we_t                                             we_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]                     head_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]                     tail_i
);

  localparam int unsigned PtrW = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] NullPtr = PtrW'(CAPACITY);

  logic [PtrW-1:0] head_q [NUM_QUEUES];
  logic [PtrW-1:0] tail_q [NUM_QUEUES];
  logic            rd_in_range;
  logic            wr_in_range;

  assign rd_in_range = 32'(rd_idx_i) < NUM_QUEUES;
  assign wr_in_range = 32'(wr_idx_i) < NUM_QUEUES;

  assign head_o = rd_in_range ? head_q[rd_idx_i] : NullPtr;
  assign tail_o = rd_in_range ? tail_q[rd_idx_i] : NullPtr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= NullPtr;
        tail_q[i] <= NullPtr;
      end
    end else begin
      if (we_i.head_we && wr_in_range) begin
        head_q[wr_idx_i] <= head_i;
      end
      if (we_i.tail_we && wr_in_range) begin
        tail_q[wr_idx_i] <= tail_i;
      end
    end
  end

endmodule

/* rtl/mqsb_checker.sv */
// ----------------------------------------------------------------------------
// mqsb_checker
// port-level checks of command and result beat timing and of status and data
// ----------------------------------------------------------------------------
module mqsb_checker import mqsb_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [StatusW-1:0]      status_o,
  input logic signed [DataW-1:0] data_out_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken without going busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result beat missing after busy cycle");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a command");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (data_out_o == '0))
    else $error("nonzero data on a rejected command");

endmodule

bind multi_queue_shared_buffer_top mqsb_checker u_mqsb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .data_out_o (data_out_o)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench of the shared-buffer multi-queue: a mirror of the queue chains and
// free list predicts each result beat, and every strobed beat is checked
// against the oldest prediction; directed corners first, then random traffic
// in enqueue-heavy, balanced and dequeue-heavy phases that fill and drain the
// store, with commands sent in bursts separated by random gaps
// ----------------------------------------------------------------------------
module tb_top import mqsb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PtrW        = $clog2(CapacityDef) + 1;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxPrinted  = 40;

  typedef logic [PtrW-1:0] ptr_t;

  typedef struct {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] data;
  } result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic                    kind_i        = KIND_ENQ;
  logic [QidxW-1:0]        queue_index_i = '0;
  logic signed [DataW-1:0] value_i       = '0;
  logic                    busy;
  logic                    done_o;
  logic [StatusW-1:0]      status_o;
  logic signed [DataW-1:0] data_out_o;

  // mirror of the block state
  logic [DataW-1:0] slot_value [CapacityDef];
  ptr_t             slot_next  [CapacityDef];
  ptr_t             head_ptr   [NumQueuesDef];
  ptr_t             tail_ptr   [NumQueuesDef];
  ptr_t             free_ptr;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  multi_queue_shared_buffer_top #(
    .NUM_QUEUES(NumQueuesDef),
    .CAPACITY  (CapacityDef)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .kind_i       (kind_i),
    .queue_index_i(queue_index_i),
    .value_i      (value_i),
    .busy         (busy),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL multi_queue_shared_buffer_top");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic bit ptr_ok(input ptr_t p);
    return p < ptr_t'(CapacityDef);
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < CapacityDef; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = ptr_t'(i + 1);
    end
    for (int i = 0; i < NumQueuesDef; i++) begin
      head_ptr[i] = ptr_t'(CapacityDef);
      tail_ptr[i] = ptr_t'(CapacityDef);
    end
    free_ptr = '0;
  endfunction

  function automatic result_t apply_queue_op(input logic kind, input logic [QidxW-1:0] q,
                                             input logic [DataW-1:0] val);
    result_t r;
    ptr_t    slot;
    ptr_t    nxt;
    r.status = ST_OK;
    r.data   = '0;
    if (kind == KIND_ENQ) begin
      if (q >= NumQueuesDef || !ptr_ok(free_ptr)) begin
        r.status = ST_FULL;
      end else begin
        slot     = free_ptr;
        nxt      = slot_next[slot];
        free_ptr = ptr_ok(nxt) ? nxt : ptr_t'(CapacityDef);
        if (!ptr_ok(head_ptr[q])) begin
          head_ptr[q] = slot;
        end else if (ptr_ok(tail_ptr[q])) begin
          slot_next[tail_ptr[q]] = slot;
        end
        slot_next[slot]  = ptr_t'(CapacityDef);
        tail_ptr[q]      = slot;
        slot_value[slot] = val;
      end
    end else begin
      if (q >= NumQueuesDef || !ptr_ok(head_ptr[q])) begin
        r.status = ST_EMPTY;
      end else begin
        slot            = head_ptr[q];
        nxt             = slot_next[slot];
        head_ptr[q]     = ptr_ok(nxt) ? nxt : ptr_t'(CapacityDef);
        slot_next[slot] = free_ptr;
        free_ptr        = slot;
        r.data          = slot_value[slot];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending (status %0d data %0h)",
                                  status_o, data_out_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        end
        if (data_out_o !== want.data) begin
          report_mismatch($sformatf("data_out %0h, expected %0h", data_out_o, want.data));
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the command
  task automatic send_cmd(input logic kind, input logic [QidxW-1:0] q,
                          input logic signed [DataW-1:0] val);
    start         <= 1'b1;
    kind_i        <= kind;
    queue_index_i <= q;
    value_i       <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(apply_queue_op(kind, q, val));
  endtask

  // bursts of back-to-back commands with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic issue(input logic kind, input logic [QidxW-1:0] q,
                       input logic signed [DataW-1:0] val);
    send_cmd(kind, q, val);
    pace();
  endtask

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extreme_values();
    issue(KIND_ENQ, 3'd0, 32'sh7fff_ffff);
    issue(KIND_ENQ, 3'd7, 32'sh8000_0000);
    issue(KIND_ENQ, 3'd0, '0);
    issue(KIND_ENQ, 3'd7, -32'sd1);
    issue(KIND_DEQ, 3'd0, 32'sh5555_5555);
    issue(KIND_DEQ, 3'd7, 32'shaaaa_aaaa);
    issue(KIND_DEQ, 3'd0, '0);
    issue(KIND_DEQ, 3'd7, '0);
  endtask

  task automatic test_empty_dequeue();
    issue(KIND_DEQ, 3'd3, -32'sd1);
    issue(KIND_DEQ, 3'd0, '0);
    issue(KIND_DEQ, 3'd5, '0);
  endtask

  // queue drained leaves its tail behind, next enqueue must start a new chain
  task automatic test_stale_tail();
    issue(KIND_ENQ, 3'd2, 32'sh0000_1111);
    issue(KIND_DEQ, 3'd2, '0);
    issue(KIND_ENQ, 3'd2, 32'sh0000_2222);
    issue(KIND_ENQ, 3'd6, 32'sh0000_6666);
    issue(KIND_ENQ, 3'd2, 32'sh0000_3333);
    issue(KIND_DEQ, 3'd2, '0);
    issue(KIND_DEQ, 3'd6, '0);
    issue(KIND_DEQ, 3'd2, '0);
    issue(KIND_DEQ, 3'd2, '0);
  endtask

  // phases bias to enqueue to hit store full, to dequeue to drain, or balanced
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned enq_pct;
    int unsigned qmax;
    logic        kind;
    sent = 0;
    while (sent < RandomItems) begin
      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 2))
        0:       enq_pct = 90;
        1:       enq_pct = 50;
        default: enq_pct = 12;
      endcase
      qmax = ($urandom_range(0, 1) == 0) ? 1 : NumQueuesDef - 1;
      for (int i = 0; i < phase_len && sent < RandomItems; i++) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        issue(kind, QidxW'($urandom_range(0, qmax)), rand_value());
        sent++;
      end
    end
  endtask

  initial begin
    clear_mirror();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_values();
    test_empty_dequeue();
    test_stale_tail();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS multi_queue_shared_buffer_top");
    end else begin
      $display("FAIL multi_queue_shared_buffer_top");
    end
    $finish;
  end

endmodule

/* multi_queue_shared_buffer_top.f */
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/mqsb_ptr_table.sv
rtl/multi_queue_shared_buffer_top.sv
rtl/mqsb_checker.sv
test/tb_top.sv
